>>> sv/sequential_list_engine_unit_assert.svh
// Assertion macros for the list engine top level.
// Include in module scope; the enclosing module must have clk and rst_n.
`ifndef SEQUENTIAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_UNIT_ASSERT_SVH

`ifndef SYNTH
`define SLE_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("sle: invariant violated");
`define SLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sle: sequence violated");
`else
`define SLE_ASSERT_ALWAYS(lbl, expr)
`define SLE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> sv/sle_pkg.sv
// Shared types and codes for the list engine.
// No dependencies; used by every module of the block.
package sle_pkg;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int FOUND_W  = 4;
  localparam int COUNT_W  = 5;
  // Wide enough for an index or a count at the largest supported depth
  localparam int BUS_W    = 9;

  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ERASE      = 3'd5;
  localparam logic [KIND_W-1:0] KIND_FIND       = 3'd6;

  localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FOUND_W-1:0]  found_index;
    logic [COUNT_W-1:0]  count;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE
  } cell_cmd_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    cell_cmd_t                 cmd;
    logic [BUS_W-1:0]          at;
    logic [BUS_W-1:0]          cnt;
    logic signed [VALUE_W-1:0] din;
  } cell_bus_t;

  typedef enum logic {
    S_IDLE,
    S_FIND
  } sle_state_t;

endpackage

>>> sv/sle_cell.sv
// One slot of the list: holds an entry, shifts with its neighbors, compares.
// Depends on sle_pkg.
module sle_cell
  import sle_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  cell_bus_t                 bus,
  input  logic signed [VALUE_W-1:0] left_val,
  input  logic signed [VALUE_W-1:0] right_val,
  output logic signed [VALUE_W-1:0] val_r,
  output logic                      match
);

  localparam logic [BUS_W-1:0] MY = BUS_W'(IDX);

  logic signed [VALUE_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (bus.cmd)
      CMD_INSERT: begin
        // slots above the gap take the lower neighbor, the gap takes the new value
        if (MY > bus.at) begin
          val_nxt = left_val;
        end else if (MY == bus.at) begin
          val_nxt = bus.din;
        end
      end
      CMD_REMOVE: begin
        if (MY >= bus.at) begin
          val_nxt = right_val;
        end
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign match = (MY < bus.cnt) && (val_r == bus.din);

endmodule

>>> sv/sle_find.sv
// First-match scanner: captures the cells' match flags, then walks them
// a group at a time, lowest index first. Depends on sle_pkg.
module sle_find
  import sle_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  logic                     scan,
  input  logic [DEPTH-1:0]         flags,
  output logic                     done,
  output logic                     hit,
  output logic [$clog2(DEPTH)-1:0] idx
);

  localparam int GROUP = (DEPTH < 8) ? DEPTH : 8;
  localparam int NGRP  = (DEPTH + GROUP - 1) / GROUP;
  localparam int PADW  = NGRP * GROUP;
  localparam int CHW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PEW   = $clog2(GROUP);
  localparam int IDXW  = $clog2(DEPTH);
  localparam logic [IDXW-1:0] GROUP_I = IDXW'(GROUP);

  logic [PADW-1:0] flags_r;
  logic [CHW-1:0]  chunk_r;
  logic [PEW-1:0]  pe;
  logic            last;

  assign hit  = |flags_r[GROUP-1:0];
  assign last = (chunk_r == CHW'(NGRP - 1));
  assign done = hit || last;

  always_comb begin
    pe = '0;
    for (int i = GROUP - 1; i >= 0; i--) begin
      if (flags_r[i]) begin
        pe = PEW'(i);
      end
    end
  end

  assign idx = IDXW'(chunk_r) * GROUP_I + IDXW'(pe);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= '0;
    end else if (load) begin
      chunk_r <= '0;
    end else if (scan && !done) begin
      chunk_r <= chunk_r + 1'b1;
    end
  end

  // advance to the next group until a match shows up or the last group is reached
  always_ff @(posedge clk) begin
    if (load) begin
      flags_r <= PADW'(flags);
    end else if (scan && !done) begin
      flags_r <= flags_r >> GROUP;
    end
  end

endmodule

>>> sv/sequential_list_engine_unit.sv
// Top level of the list engine: request decode, chain of cells, find scanner.
// Depends on sle_pkg, sle_cell, sle_find and sequential_list_engine_unit_assert.svh.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_ready  in_item_t  (kind, position, value)
//   out_     output     out_valid/out_ready  out_item_t (status, found_index, count)
//
// Every kind but find is done in the accept cycle: cells shift or load and the
// result is registered at that edge, so such items flow at one per cycle while
// the output is not stalled. Find captures the match flags and the scanner walks
// them eight slots (DEPTH if smaller) per cycle until a match or the last group.
// Reset clears count, state and output valid, not the entries. A stalled result
// holds in the output register and blocks the next item until the cycle it is taken.
`include "sequential_list_engine_unit_assert.svh"

module sequential_list_engine_unit
  import sle_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IDXW = $clog2(DEPTH);

  sle_state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r, cnt_d;
  logic          full, empty;
  logic          accept, is_find;
  logic [BUS_W-1:0] pos_b, cnt_b;

  cell_cmd_t        cmd_d;
  logic [BUS_W-1:0] at_d;
  logic [STATUS_W-1:0] status_d;
  cell_bus_t        bus;

  logic signed [VALUE_W-1:0] vals [DEPTH];
  logic [DEPTH-1:0]          match_flags;

  logic            find_done, find_hit;
  logic [IDXW-1:0] find_idx;

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      out_load;
  out_item_t out_nxt;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign pos_b   = BUS_W'(in_data.position);
  assign cnt_b   = BUS_W'(cnt_r);
  assign is_find = (in_data.kind == KIND_FIND);
  assign in_ready = rst_n && (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept  = in_valid && in_ready;

  // request decode
  always_comb begin
    cmd_d    = CMD_HOLD;
    at_d     = '0;
    status_d = STAT_OK;
    cnt_d    = cnt_r;
    unique case (in_data.kind) inside
      KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          cmd_d = CMD_INSERT;
          at_d  = (in_data.kind == KIND_PUSH_BACK) ? cnt_b : '0;
          cnt_d = cnt_r + 1'b1;
        end
      end
      KIND_POP_BACK: begin
        // dropping the last entry moves nothing
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          cnt_d = cnt_r - 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          cmd_d = CMD_REMOVE;
          cnt_d = cnt_r - 1'b1;
        end
      end
      KIND_INSERT: begin
        if (full) begin
          status_d = STAT_FULL;
        end else if (pos_b > cnt_b) begin
          status_d = STAT_RANGE;
        end else begin
          cmd_d = CMD_INSERT;
          at_d  = pos_b;
          cnt_d = cnt_r + 1'b1;
        end
      end
      KIND_ERASE: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else if (pos_b >= cnt_b) begin
          status_d = STAT_RANGE;
        end else begin
          cmd_d = CMD_REMOVE;
          at_d  = pos_b;
          cnt_d = cnt_r - 1'b1;
        end
      end
      default: begin
        // find and the unused code leave the list alone
        cmd_d = CMD_HOLD;
      end
    endcase
  end

  assign bus.cmd = accept ? cmd_d : CMD_HOLD;
  assign bus.at  = at_d;
  assign bus.cnt = cnt_b;
  assign bus.din = in_data.value;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VALUE_W-1:0] left_v, right_v;
    if (g == 0) begin : g_first
      assign left_v = in_data.value;
    end else begin : g_mid_l
      assign left_v = vals[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_v = in_data.value;
    end else begin : g_mid_r
      assign right_v = vals[g+1];
    end
    sle_cell #(
      .IDX(g)
    ) u_cell (
      .clk      (clk),
      .bus      (bus),
      .left_val (left_v),
      .right_val(right_v),
      .val_r    (vals[g]),
      .match    (match_flags[g])
    );
  end

  sle_find #(
    .DEPTH(DEPTH)
  ) u_find (
    .clk  (clk),
    .rst_n(rst_n),
    .load (accept && is_find),
    .scan (state_r == S_FIND),
    .flags(match_flags),
    .done (find_done),
    .hit  (find_hit),
    .idx  (find_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    out_nxt   = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_find) begin
            state_nxt = S_FIND;
          end else begin
            out_load            = 1'b1;
            out_nxt.status      = status_d;
            out_nxt.found_index = '0;
            out_nxt.count       = COUNT_W'(cnt_d);
          end
        end
      end
      S_FIND: begin
        if (find_done) begin
          out_load            = 1'b1;
          out_nxt.status      = find_hit ? STAT_OK : STAT_NOTFOUND;
          out_nxt.found_index = find_hit ? FOUND_W'(find_idx) : '0;
          out_nxt.count       = COUNT_W'(cnt_r);
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= cnt_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SLE_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CW'(DEPTH))
  `SLE_ASSERT_ALWAYS(a_find_slot_free, !(state_r == S_FIND && out_valid_r))
  `SLE_ASSERT_NEXT(a_plain_result, accept && !is_find, out_valid_r && state_r == S_IDLE)
  `SLE_ASSERT_NEXT(a_find_keeps_cnt, state_r == S_FIND, cnt_r == $past(cnt_r))

endmodule
